### design/first_fit_pool_allocator_assert.svh
// Assertion macros for the first-fit pool allocator.
// Needs clk and rst_n in scope at each place of use.
`ifndef FIRST_FIT_POOL_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFPA_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFPA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ffpa_pkg.sv
// Shared types and codes for the first-fit pool allocator.
// No dependencies.
package ffpa_pkg;

  localparam int ADDR_W = 16;
  localparam int SIZE_W = 17;
  localparam int FILL_W = 17;

  localparam logic [SIZE_W-1:0] ROUND_ADD  = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] ROUND_MASK = ~SIZE_W'(3);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_UNKNOWN    = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] bytes;
    logic              is_free;
  } ffpa_entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic emit;
  } ffpa_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic out_busy;
  } ffpa_sts_t;

endpackage

### design/ffpa_ctrl.sv
// Sequencer of the first-fit pool allocator: accept, table walk, result.
// Depends on ffpa_pkg.
module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ffpa_sts_t sts,
  output ffpa_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    cmd.emit   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.scan_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_RESULT;
        end
      end
      S_RESULT: begin
        // wait for the output register to drain
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    in_stall_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule

### design/ffpa_dp.sv
// Datapath of the first-fit pool allocator: block table, walk pointer,
// bump allocation and the result register. Depends on ffpa_pkg.
module ffpa_dp
  import ffpa_pkg::*;
#(
  parameter int unsigned POOL_BYTES   = 65536,
  parameter int unsigned MAX_BLOCKS   = 256,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ffpa_cmd_t         cmd,
  output ffpa_sts_t         sts,
  input  logic              in_op,
  input  logic [ADDR_W-1:0] in_request_size,
  input  logic [ADDR_W-1:0] in_free_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_data_address,
  output logic              out_reused
);

`include "first_fit_pool_allocator_assert.svh"

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  ffpa_entry_t mem [MAX_BLOCKS];

  logic              op_r;
  logic [SIZE_W-1:0] need_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CW-1:0]     rd_idx_r;
  logic [IW-1:0]     chk_idx_r;
  logic              chk_vld_r, chk_vld_nxt;
  ffpa_entry_t       rdata_r;

  logic [1:0]        res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic              res_reused_r, res_reused_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_reused_r;

  logic              rd_en;
  logic              match, hit;
  logic [SIZE_W-1:0] rd_data_addr;
  logic [FILL_W:0]   fill_hdr, total;
  logic              exhausted, full;
  logic              wr_en;
  logic [IW-1:0]     wr_idx;
  ffpa_entry_t       wr_data;

  assign rd_en        = cmd.scan && (rd_idx_r < count_r);
  assign rd_data_addr = {1'b0, rdata_r.start} + SIZE_W'(HEADER_BYTES);
  assign match = (op_r == OP_ALLOC) ? (rdata_r.is_free && (rdata_r.bytes >= need_r))
                                    : (rd_data_addr == {1'b0, addr_r});
  assign hit   = chk_vld_r && match;

  assign sts.hit       = hit;
  assign sts.scan_done = !chk_vld_r && !(rd_idx_r < count_r);
  assign sts.out_busy  = out_valid_r && out_stall;

  assign fill_hdr  = {1'b0, fill_r} + (FILL_W+1)'(HEADER_BYTES);
  assign total     = fill_hdr + {1'b0, need_r};
  assign exhausted = (total > (FILL_W+1)'(POOL_BYTES)) ||
                     (fill_hdr > (FILL_W+1)'(16'hFFFF));
  assign full      = (count_r >= CW'(MAX_BLOCKS));

  always_comb begin
    wr_en          = 1'b0;
    wr_idx         = chk_idx_r;
    wr_data        = rdata_r;
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_reused_nxt = res_reused_r;
    if (cmd.commit) begin
      res_status_nxt = ST_OK;
      res_addr_nxt   = '0;
      res_reused_nxt = 1'b0;
      if (hit) begin
        // first fit or free target found: rewrite its free mark
        wr_en           = 1'b1;
        wr_data.is_free = (op_r == OP_FREE);
        if (op_r == OP_ALLOC) begin
          res_addr_nxt   = rd_data_addr[ADDR_W-1:0];
          res_reused_nxt = 1'b1;
        end
      end else if (op_r == OP_FREE) begin
        res_status_nxt = ST_UNKNOWN;
      end else if (exhausted) begin
        res_status_nxt = ST_EXHAUSTED;
      end else if (full) begin
        res_status_nxt = ST_TABLE_FULL;
      end else begin
        wr_en           = 1'b1;
        wr_idx          = count_r[IW-1:0];
        wr_data.start   = fill_r[ADDR_W-1:0];
        wr_data.bytes   = need_r;
        wr_data.is_free = 1'b0;
        count_nxt       = count_r + CW'(1);
        fill_nxt        = total[FILL_W-1:0];
        res_addr_nxt    = fill_hdr[ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    if (cmd.load) begin
      chk_vld_nxt = 1'b0;
    end else if (cmd.scan) begin
      chk_vld_nxt = rd_en;
    end else begin
      chk_vld_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // block table: one read port (registered), one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_idx_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fill_r      <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      need_r   <= ({1'b0, in_request_size} + ROUND_ADD) & ROUND_MASK;
      addr_r   <= in_free_address;
      rd_idx_r <= '0;
    end else if (rd_en) begin
      rd_idx_r  <= rd_idx_r + CW'(1);
      chk_idx_r <= rd_idx_r[IW-1:0];
    end
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_reused_r <= res_reused_nxt;
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_reused_r <= res_reused_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_data_address = out_addr_r;
  assign out_reused       = out_reused_r;

  `FFPA_CHECK(a_count_bound, 1'b1, count_r <= CW'(MAX_BLOCKS), "block count past table size")
  `FFPA_CHECK(a_fill_bound, 1'b1, fill_r <= FILL_W'(POOL_BYTES), "fill mark past pool end")
  `FFPA_CHECK(a_hit_in_range, hit, CW'(chk_idx_r) < count_r, "hit on unwritten table entry")
  `FFPA_CHECK_NEXT(a_emit_valid, cmd.emit, out_valid_r, "result lost at output register")

endmodule

### design/first_fit_pool_allocator.sv
// First-fit pool allocator, top level.
// Input channel (in_valid/in_stall): in_op selects allocate (request size) or
// free (data offset). One transfer in gives exactly one transfer out on the
// result channel (out_valid/out_stall): status, data offset, reused flag.
// Requests are handled one at a time. An accepted request walks the block
// table one entry per cycle through the table's single read port, stopping at
// the first match; the next request is taken only after the result has been
// moved to the output register. in_stall stays high while a request is in work.
// The result sits in an output register; a stalled receiver holds it there,
// and the block finishes the next request's walk meanwhile, then waits until
// the register drains. Reset (rst_n low, synchronous) empties the table and
// the pool fill mark and drops out_valid; no clearing pass is needed, since
// only entries already written are read.
// Depends on ffpa_pkg, ffpa_ctrl, ffpa_dp.
module first_fit_pool_allocator
  import ffpa_pkg::*;
#(
  parameter int unsigned POOL_BYTES   = 65536,
  parameter int unsigned MAX_BLOCKS   = 256,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [ADDR_W-1:0] in_request_size,
  input  logic [ADDR_W-1:0] in_free_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_data_address,
  output logic              out_reused
);

  ffpa_cmd_t cmd;
  ffpa_sts_t sts;

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffpa_dp #(
    .POOL_BYTES   (POOL_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_request_size  (in_request_size),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_data_address (out_data_address),
    .out_reused       (out_reused)
  );

endmodule

### test/ffpa_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the first-fit pool allocator bench: a shadow block table that
// predicts every reply, and the queue of replies still due. Depends on ffpa_pkg.
package ffpa_tb_pkg;
  import ffpa_pkg::*;

  localparam int POOL_BYTES   = 65536;
  localparam int MAX_BLOCKS   = 256;
  localparam int HEADER_BYTES = 8;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] data_address;
    logic              reused;
  } reply_t;

  class pool_scoreboard;
    logic [ADDR_W-1:0] hdr_at   [MAX_BLOCKS];
    logic [SIZE_W-1:0] bytes_at [MAX_BLOCKS];
    bit                free_at  [MAX_BLOCKS];
    int                n_blocks;
    int                fill_mark;
    reply_t            replies_due [$];
    int                errors;

    // first fit over the table, else bump from the fill mark
    function reply_t place(logic [ADDR_W-1:0] req);
      logic [SIZE_W-1:0] need;
      reply_t            r;
      int                total;
      int                i;
      need = (SIZE_W'(req) + ROUND_ADD) & ROUND_MASK;
      r = '0;
      r.status = ST_OK;
      for (i = 0; i < n_blocks; i++) begin
        if (free_at[i] && bytes_at[i] >= need) begin
          free_at[i] = 1'b0;
          r.data_address = hdr_at[i] + ADDR_W'(HEADER_BYTES);
          r.reused = 1'b1;
          return r;
        end
      end
      total = HEADER_BYTES + int'(need);
      // exhaustion wins over a full table
      if (fill_mark + total > POOL_BYTES || fill_mark + HEADER_BYTES > 'hFFFF) begin
        r.status = ST_EXHAUSTED;
      end else if (n_blocks >= MAX_BLOCKS) begin
        r.status = ST_TABLE_FULL;
      end else begin
        hdr_at[n_blocks]   = ADDR_W'(fill_mark);
        bytes_at[n_blocks] = need;
        free_at[n_blocks]  = 1'b0;
        n_blocks++;
        r.data_address = ADDR_W'(fill_mark + HEADER_BYTES);
        fill_mark += total;
      end
      return r;
    endfunction

    function reply_t mark_free(logic [ADDR_W-1:0] addr);
      reply_t r;
      int     i;
      r = '0;
      r.status = ST_UNKNOWN;
      if (addr == '0) return r;
      for (i = 0; i < n_blocks; i++) begin
        if (int'(hdr_at[i]) + HEADER_BYTES == int'(addr)) begin
          free_at[i] = 1'b1;
          r.status = ST_OK;
          return r;
        end
      end
      return r;
    endfunction

    function void note_request(logic op, logic [ADDR_W-1:0] req, logic [ADDR_W-1:0] addr);
      if (op == OP_FREE) replies_due.push_back(mark_free(addr));
      else replies_due.push_back(place(req));
    endfunction

    function void check_reply(logic [1:0] st, logic [ADDR_W-1:0] da, logic re);
      reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: reply with no request pending: status %0d addr %0d reused %0d",
                 $time, st, da, re);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (st !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, st);
        errors++;
      end
      if (da !== want.data_address) begin
        $display("%0t: data_address mismatch: expected %0d, actual %0d",
                 $time, want.data_address, da);
        errors++;
      end
      if (re !== want.reused) begin
        $display("%0t: reused mismatch: expected %0d, actual %0d", $time, want.reused, re);
        errors++;
      end
    endfunction
  endclass

endpackage

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for first_fit_pool_allocator: directed then random requests
// with random idling on both channels. Depends on ffpa_pkg and ffpa_tb_pkg.
module tb_top;
  import ffpa_pkg::*;
  import ffpa_tb_pkg::*;

  localparam int RANDOM_ITEMS   = 2000;
  localparam int LONG_HOLD      = 3000;
  localparam int WATCHDOG_LIMIT = 15000;
  localparam int DRAIN_CYCLES   = 300;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_op;
  logic [ADDR_W-1:0] in_request_size;
  logic [ADDR_W-1:0] in_free_address;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_data_address;
  logic              out_reused;

  pool_scoreboard sb;
  int             results_seen;
  int             quiet_cycles;
  bit             no_idle;
  int             hold_left;
  bit             held_early;
  bit             held_late;
  bit             moved;

  first_fit_pool_allocator #(
    .POOL_BYTES  (POOL_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_request_size (in_request_size),
    .in_free_address (in_free_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_address(out_data_address),
    .out_reused      (out_reused)
  );

  always #4 clk = ~clk;

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Growth phase: small sizes so the table fills before the pool; the last
  // slot is sized to leave 12 bytes, right at the full-table/exhausted edge.
  function automatic logic [ADDR_W-1:0] pick_alloc_size();
    int r;
    int room;
    room = POOL_BYTES - sb.fill_mark - HEADER_BYTES;
    r = $urandom_range(0, 99);
    if (sb.n_blocks == MAX_BLOCKS - 1) return ADDR_W'(room > 12 ? room - 12 : 0);
    if (r < 40 || (sb.n_blocks < MAX_BLOCKS && r < 80))
      return ADDR_W'($urandom_range(0, 128));
    if (r < 55 || (sb.n_blocks < MAX_BLOCKS && r < 90))
      return ADDR_W'($urandom_range(129, 1024));
    if (sb.n_blocks < MAX_BLOCKS) return ADDR_W'($urandom_range(room + 1, 65535));
    if (r < 70) return ADDR_W'($urandom_range(room > 8 ? room - 8 : 0, room + 8));
    return ADDR_W'($urandom);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_free_address();
    int r;
    int base;
    r = $urandom_range(0, 99);
    if (sb.n_blocks == 0 || r < 10) return ADDR_W'($urandom);
    if (r < 18) return '0;
    base = int'(sb.hdr_at[$urandom_range(0, sb.n_blocks - 1)]) + HEADER_BYTES;
    if (r < 30) begin
      case ($urandom_range(0, 3))
        0: base = base - 8;
        1: base = base - 4;
        2: base = base + 4;
        default: base = base + 1;
      endcase
    end
    return ADDR_W'(base);
  endfunction

  // Called at a falling edge; returns at a falling edge after the transfer
  // and any idle gap.
  task automatic offer(input logic op, input logic [ADDR_W-1:0] size,
                       input logic [ADDR_W-1:0] addr);
    int n;
    in_valid        <= 1'b1;
    in_op           <= op;
    in_request_size <= size;
    in_free_address <= addr;
    do @(posedge clk); while (in_stall);
    n = gap_len();
    @(negedge clk);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        sb.note_request(in_op, in_request_size, in_free_address);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_reply(out_status, out_data_address, out_reused);
        results_seen++;
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(100, 600)) @(posedge clk);
      no_idle = ($urandom_range(0, 3) == 0);
    end
  end

  // Receiver: random stalls, plus two long hold-offs that back up the input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if ((!held_early && results_seen >= 40) ||
                   (!held_late && results_seen >= 1000)) begin
        if (!held_early) held_early = 1'b1;
        else held_late = 1'b1;
        out_stall <= 1'b1;
        hold_left = LONG_HOLD - 1;
      end else begin
        hold_left = gap_len();
        out_stall <= (hold_left > 0);
        if (hold_left > 0) hold_left--;
      end
    end
  end

  initial begin
    sb = new;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_ALLOC;
    in_request_size = '0;
    in_free_address = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer(OP_FREE,  16'd0,     16'd0);      // null free
    offer(OP_FREE,  16'hFFFF,  16'd8);      // free on an empty table
    offer(OP_ALLOC, 16'd0,     16'hFFFF);   // zero-byte block
    offer(OP_ALLOC, 16'd1,     16'd0);
    offer(OP_ALLOC, 16'd3,     16'd0);
    offer(OP_ALLOC, 16'd5,     16'd0);
    offer(OP_ALLOC, 16'hFFFF,  16'd0);      // rounds to a 17-bit size
    offer(OP_ALLOC, 16'd65533, 16'd0);
    offer(OP_ALLOC, 16'd65532, 16'd0);
    offer(OP_FREE,  16'd0,     16'd16);
    offer(OP_FREE,  16'd0,     16'd16);     // double free
    offer(OP_FREE,  16'd0,     16'd20);     // header offset, not data
    offer(OP_FREE,  16'd0,     16'hFFFF);
    offer(OP_ALLOC, 16'd8,     16'd0);      // freed block too small
    offer(OP_ALLOC, 16'd2,     16'd0);
    offer(OP_FREE,  16'd0,     16'd8);
    offer(OP_ALLOC, 16'd0,     16'd0);
    offer(OP_FREE,  16'd0,     16'd40);
    offer(OP_FREE,  16'd0,     16'd16);
    offer(OP_ALLOC, 16'd4,     16'd0);      // first fit takes the lower block
    offer(OP_ALLOC, 16'd6,     16'd0);
    offer(OP_FREE,  16'd0,     16'd56);
    offer(OP_ALLOC, 16'd9,     16'd0);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 99) < (sb.n_blocks < MAX_BLOCKS ? 30 : 40))
        offer(OP_FREE, ADDR_W'($urandom), pick_free_address());
      else
        offer(OP_ALLOC, pick_alloc_size(), ADDR_W'($urandom));
    end
    in_valid <= 1'b0;

    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/ffpa_pkg.sv
design/ffpa_ctrl.sv
design/ffpa_dp.sv
design/first_fit_pool_allocator.sv
test/ffpa_tb_pkg.sv
test/tb_top.sv
